FILE: rtl/itrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to radix text package
// Shared widths, constants, cell link types and character helpers.
// ----------------------------------------------------------------------------
package itrt_pkg;

  localparam int WORD_BITS = 32;
  localparam int VALUE_W   = 32;
  localparam int DIGIT_W   = 6;
  localparam int CHAR_W    = 8;
  localparam int NCELLS    = WORD_BITS;
  localparam int CNT_W     = $clog2(2 * WORD_BITS);
  localparam int IDX_W     = $clog2(NCELLS);

  localparam logic [DIGIT_W-1:0] RADIX_MIN = DIGIT_W'(2);
  localparam logic [DIGIT_W-1:0] RADIX_MAX = DIGIT_W'(36);
  localparam logic [DIGIT_W-1:0] RADIX_TEN = DIGIT_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER = 8'h61;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic               en;
    logic               carry;
    logic [DIGIT_W-1:0] digit;
    logic               occ;
  } itrt_link_t;

  typedef struct packed {
    logic               clear;
    logic               shift;
    logic [DIGIT_W-1:0] radix;
  } itrt_ctrl_t;

  function automatic word_t to_word(input logic [VALUE_W-1:0] v);
    word_t w;
    w = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (i < VALUE_W) begin
        w[i] = v[i];
      end
    end
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] de;
    de = {{(CHAR_W - DIGIT_W){1'b0}}, d};
    if (d < RADIX_TEN) begin
      return CHAR_ZERO + de;
    end
    if (upper) begin
      return CHAR_UPPER + de - CHAR_W'(10);
    end
    return CHAR_LOWER + de - CHAR_W'(10);
  endfunction

endpackage

FILE: rtl/itrt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to radix text channels
// Valid/ready channels for the request items and the character items.
// ----------------------------------------------------------------------------
interface itrt_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        is_signed;
  logic [5:0]  radix;

  modport source(output valid, value, is_signed, radix, input ready);
  modport sink(input valid, value, is_signed, radix, output ready);
endinterface

interface itrt_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source(output valid, char_code, last, input ready);
  modport sink(input valid, char_code, last, output ready);
endinterface

FILE: rtl/itrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to radix text digit cell
// Holds one digit; doubles it with a carry from its lower neighbor while
// converting, and passes its digit upward while the text is shifted out.
// ----------------------------------------------------------------------------
module itrt_cell
  import itrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  itrt_ctrl_t ctrl,
  input  itrt_link_t left,
  output itrt_link_t right
);

  logic [DIGIT_W-1:0] digit;
  logic               occ;
  logic               en_q;
  logic               carry_q;

  logic [DIGIT_W:0]   dbl;
  logic [DIGIT_W:0]   diff;
  logic               ge;
  logic [DIGIT_W-1:0] digit_next;

  always_comb begin
    dbl        = {digit, 1'b0} + {{DIGIT_W{1'b0}}, left.carry};
    diff       = dbl - {1'b0, ctrl.radix};
    ge         = dbl >= {1'b0, ctrl.radix};
    digit_next = ge ? diff[DIGIT_W-1:0] : dbl[DIGIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      en_q    <= 1'b0;
      carry_q <= 1'b0;
      occ     <= 1'b0;
    end else begin
      en_q    <= left.en;
      carry_q <= left.en & ge;
      if (ctrl.clear) begin
        occ <= 1'b0;
      end else if (ctrl.shift) begin
        occ <= left.occ;
      end else if (left.en) begin
        occ <= occ | left.carry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.shift) begin
      digit <= left.digit;
    end else if (left.en) begin
      digit <= digit_next;
    end
  end

  assign right.en    = en_q;
  assign right.carry = carry_q;
  assign right.digit = digit;
  assign right.occ   = occ;

endmodule

FILE: rtl/integer_to_radix_text.sv
`timescale 1ns / 1ps
// Flow: the request is accepted, the word is converted through the skewed cell row, and the
// cell row is shifted out, after a minus sign for a negative value, to the last character.
// A new request is taken only in IDLE, once the last character of the previous one is loaded
// for output; stalls on the text side hold the shift-out of the cell row.
// Reset: rst clears the state machine, the output valid, the cell tokens and the letter case.
// ----------------------------------------------------------------------------
// Integer to radix text
// Converts a word to ASCII digits in radix 2 to 36, most significant first.
// ----------------------------------------------------------------------------
module integer_to_radix_text
  import itrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  itrt_req_if.sink   request,
  itrt_text_if.source text
);

  typedef enum logic [1:0] {IDLE, CONV, SIGN, EMIT} state_t;

  state_t             state;
  logic               upper;
  logic [DIGIT_W-1:0] radix;
  logic               neg;
  word_t              word_sh;
  logic [CNT_W-1:0]   cnt;
  logic [IDX_W-1:0]   eidx;
  logic               out_valid;
  logic [CHAR_W-1:0]  out_char;
  logic               out_last;

  itrt_link_t         link [NCELLS+1];
  itrt_ctrl_t         ctrl;

  word_t              in_word;
  logic [DIGIT_W-1:0] in_radix;
  logic               in_neg;
  logic               accept;
  logic               slot_free;
  logic               emit_now;
  logic               advance;
  logic               final_pos;
  logic               load_out;

  always_comb begin
    in_word = to_word(request.value);
    if (request.radix < RADIX_MIN) begin
      in_radix = RADIX_MIN;
    end else if (request.radix > RADIX_MAX) begin
      in_radix = RADIX_MAX;
    end else begin
      in_radix = request.radix;
    end
    in_neg    = request.is_signed & (in_radix == RADIX_TEN) & in_word[WORD_BITS-1];
    accept    = request.valid & request.ready;
    slot_free = ~out_valid | text.ready;
    final_pos = eidx == IDX_W'(NCELLS - 1);
    emit_now  = link[NCELLS].occ | final_pos;
    advance   = (state == EMIT) & (~emit_now | slot_free);
    load_out  = ((state == SIGN) & slot_free) | (advance & emit_now);
  end

  assign request.ready = state == IDLE;

  assign ctrl.clear = accept;
  assign ctrl.shift = advance;
  assign ctrl.radix = radix;

  assign link[0].en    = (state == CONV) & (cnt < CNT_W'(WORD_BITS));
  assign link[0].carry = word_sh[WORD_BITS-1];
  assign link[0].digit = '0;
  assign link[0].occ   = 1'b0;

  for (genvar j = 0; j < NCELLS; j++) begin : g_cell
    itrt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .left  (link[j]),
      .right (link[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper <= 1'b0;
    end else if (cfg_wr_en) begin
      upper <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cnt       <= '0;
      eidx      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (text.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            state <= CONV;
            cnt   <= '0;
          end
        end
        CONV: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(2 * WORD_BITS - 2)) begin
            eidx  <= '0;
            state <= neg ? SIGN : EMIT;
          end
        end
        SIGN: begin
          if (slot_free) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (advance) begin
            eidx <= eidx + IDX_W'(1);
            if (final_pos) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      radix   <= in_radix;
      neg     <= in_neg;
      word_sh <= in_neg ? (~in_word + word_t'(1)) : in_word;
    end else if (state == CONV) begin
      word_sh <= {word_sh[WORD_BITS-2:0], 1'b0};
    end
    if ((state == SIGN) && slot_free) begin
      out_char <= CHAR_MINUS;
      out_last <= 1'b0;
    end else if (advance && emit_now) begin
      out_char <= digit_char(link[NCELLS].digit, upper);
      out_last <= final_pos;
    end
  end

  assign text.valid     = out_valid;
  assign text.char_code = out_char;
  assign text.last      = out_last;

`ifndef SYNTHESIS
  a_no_top_carry: assert property (@(posedge clk) disable iff (rst)
    link[NCELLS].en |-> !link[NCELLS].carry)
    else $error("Carry left the top digit cell.");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (text.valid && text.char_code == CHAR_MINUS) |-> !text.last)
    else $error("A minus sign was marked as the final character.");

  a_final_marked: assert property (@(posedge clk) disable iff (rst)
    (advance && final_pos) |=> (text.valid && text.last))
    else $error("The final digit did not appear with its last mark.");
`endif

endmodule

FILE: test/itrt_text_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to radix text checker
// Watches the request and text channels and the letter case register. For
// every accepted request it works out the characters that the block must
// emit, and it compares each accepted character item with the oldest one.
// ----------------------------------------------------------------------------
module itrt_text_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  itrt_req_if         req,
  itrt_text_if        txt,
  output int          fail_count,
  output int          chars_pending
);

  localparam logic [31:0] RADIX_LOW  = 32'd2;
  localparam logic [31:0] RADIX_HIGH = 32'd36;
  localparam logic [31:0] DECIMAL    = 32'd10;

  localparam logic [7:0] ASCII_MINUS   = 8'h2D;
  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  text_char_t chars_due[$];
  logic       letters_upper;
  int         fails;

  function automatic void predict_digits(input logic [31:0] word_in, input logic signed_mode,
                                         input logic [5:0] radix_in);
    logic [31:0] w;
    logic [31:0] base;
    logic [5:0]  digits[32];
    logic [7:0]  ch;
    int          nd;
    w    = word_in;
    base = {26'd0, radix_in};
    if (base < RADIX_LOW) begin
      base = RADIX_LOW;
    end
    if (base > RADIX_HIGH) begin
      base = RADIX_HIGH;
    end
    nd = 0;
    if (signed_mode && base == DECIMAL && w[31]) begin
      chars_due.push_back('{ASCII_MINUS, 1'b0});
      w = -w;
    end
    do begin
      digits[nd] = 6'(w % base);
      nd++;
      w = w / base;
    end while (w != 32'd0);
    for (int k = nd - 1; k >= 0; k--) begin
      if (digits[k] < 6'd10) begin
        ch = ASCII_ZERO + 8'(digits[k]);
      end else begin
        ch = (letters_upper ? ASCII_UPPER_A : ASCII_LOWER_A) + 8'(digits[k]) - 8'd10;
      end
      chars_due.push_back('{ch, (k == 0)});
    end
  endfunction

  initial begin
    letters_upper = 1'b0;
    fails         = 0;
    fail_count    = 0;
    chars_pending = 0;
  end

  always @(posedge clk) begin
    text_char_t want;
    if (rst) begin
      letters_upper = 1'b0;
    end else begin
      if (cfg_wr_en) begin
        letters_upper = cfg_wr_data;
      end
      if (req.valid && req.ready) begin
        predict_digits(req.value, req.is_signed, req.radix);
      end
      if (txt.valid && txt.ready) begin
        if (chars_due.size() == 0) begin
          $error("unexpected item: char_code %h last %b", txt.char_code, txt.last);
          fails++;
        end else begin
          want = chars_due.pop_front();
          if (txt.char_code !== want.code) begin
            $error("char_code: expected %h, actual %h", want.code, txt.char_code);
            fails++;
          end
          if (txt.last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, txt.last);
            fails++;
          end
        end
      end
    end
    fail_count    <= fails;
    chars_pending <= chars_due.size();
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to radix text testbench
// Sends directed and random conversion requests in both letter cases, with
// random idle bursts on both channels and a long hold on the text side, and
// reports the verdict from the checker's failure count and pending characters.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LONG_HOLD   = 600;
  localparam int SETTLE      = 100;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;
  logic idle_on;
  int   hold_requests;
  int   hold_served;
  int   fail_count;
  int   chars_pending;

  itrt_req_if  req_ch ();
  itrt_text_if text_ch ();

  integer_to_radix_text dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .request    (req_ch),
    .text       (text_ch)
  );

  itrt_text_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .req          (req_ch),
    .txt          (text_ch),
    .fail_count   (fail_count),
    .chars_pending(chars_pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #6000000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    hold_served  = 0;
    text_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_requests != hold_served) begin
        hold_served++;
        text_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        text_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        text_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic offer_request(input logic [31:0] v, input logic s, input logic [5:0] r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.value     <= v;
    req_ch.is_signed <= s;
    req_ch.radix     <= r;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  task automatic drain_text();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (chars_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_letter_case(input logic upper);
    drain_text();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= upper;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_random_batch(input int count, input int pause_at);
    logic [31:0] v;
    logic [5:0]  r;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) begin
        drain_text();
      end
      case ($urandom_range(0, 4))
        0: v = $urandom();
        1: v = $urandom_range(0, 40);
        2: v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 40)
                                    : 32'hFFFF_FFFF - $urandom_range(0, 40);
        3: v = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
        default: v = $urandom() >> $urandom_range(0, 31);
      endcase
      case ($urandom_range(0, 9))
        0: r = 6'($urandom_range(0, 63));
        1, 2: r = 6'd10;
        default: r = 6'($urandom_range(2, 36));
      endcase
      offer_request(v, 1'($urandom_range(0, 1)), r);
    end
  endtask

  initial begin
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = 1'b0;
    idle_on          = 1'b1;
    hold_requests    = 0;
    req_ch.valid     = 1'b0;
    req_ch.value     = 32'd0;
    req_ch.is_signed = 1'b0;
    req_ch.radix     = 6'd10;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_letter_case(1'b0);
    offer_request(32'd0, 1'b0, 6'd10);
    offer_request(32'hFFFF_FFFF, 1'b0, 6'd2);
    offer_request(32'hFFFF_FFFF, 1'b1, 6'd10);
    offer_request(32'h8000_0000, 1'b1, 6'd10);
    offer_request(32'h7FFF_FFFF, 1'b1, 6'd10);
    offer_request(32'hFFFF_FFFF, 1'b0, 6'd36);
    offer_request(32'h8000_0000, 1'b1, 6'd16);
    offer_request(32'd5, 1'b0, 6'd0);
    offer_request(32'd5, 1'b1, 6'd1);
    offer_request(32'd123456, 1'b0, 6'd37);
    offer_request(32'd35, 1'b0, 6'd63);
    offer_request(32'd35, 1'b0, 6'd36);
    offer_request(32'd0, 1'b1, 6'd10);
    offer_request(32'd10, 1'b0, 6'd11);
    offer_request(32'hDEAD_BEEF, 1'b0, 6'd16);
    offer_request(32'hFFFF_FFF6, 1'b1, 6'd10);
    offer_request(32'h1234_5678, 1'b1, 6'd8);
    offer_request(32'd9, 1'b0, 6'd10);

    set_letter_case(1'b1);
    offer_request(32'hDEAD_BEEF, 1'b0, 6'd16);
    offer_request(32'd35, 1'b0, 6'd36);
    offer_request(32'hFFFF_FFFF, 1'b1, 6'd36);
    offer_request(32'd35, 1'b1, 6'd63);

    drain_text();
    hold_requests <= hold_requests + 1;
    send_random_batch(150, -1);

    set_letter_case(1'b0);
    send_random_batch(150, 75);

    set_letter_case(1'b1);
    idle_on <= 1'b0;
    send_random_batch(110, -1);

    drain_text();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && chars_pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

FILE: integer_to_radix_text.f
rtl/itrt_pkg.sv
rtl/itrt_if.sv
rtl/itrt_cell.sv
rtl/integer_to_radix_text.sv
test/itrt_text_checker.sv
test/tb_top.sv
